/* src/mfm_pkg.sv */
// Package for the mains frequency monitor: field widths, register map,
// sequencer states and reset defaults. No dependencies.
`default_nettype none

package mfm_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 32;
  localparam int unsigned CLK_W = 24;
  localparam int unsigned FREQ_W = 8;
  localparam int unsigned BAD_W = 16;
  localparam int unsigned TMO_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [31:0] word_t;
  typedef logic [CLK_W-1:0] clk_hz_t;
  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [BAD_W-1:0] bad_t;
  typedef logic [TMO_W-1:0] tmo_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TIMER_CLOCK = 3'd0;
  localparam cfg_idx_t CFG_TARGET = 3'd1;
  localparam cfg_idx_t CFG_TOLERANCE = 3'd2;
  localparam cfg_idx_t CFG_BAD_LIMIT = 3'd3;
  localparam cfg_idx_t CFG_TIMEOUT = 3'd4;
  localparam cfg_idx_t CFG_INTERVAL = 3'd5;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam clk_hz_t RST_TIMER_CLOCK = 24'd100000;
  localparam freq_t RST_TARGET = 8'd50;
  localparam freq_t RST_TOLERANCE = 8'd5;
  localparam bad_t RST_BAD_LIMIT = 16'd10;
  localparam tmo_t RST_TIMEOUT = 16'd100;
  localparam word_t RST_INTERVAL = 32'd1000;

  localparam freq_t FREQ_MAX = 8'd255;
  localparam bad_t BAD_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP,
    ST_DIV,
    ST_EVAL,
    ST_BAD,
    ST_OUT
  } mfm_state_t;

endpackage

`default_nettype wire

/* src/mfm_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Uses mfm_pkg only through its parent's parameters.
`default_nettype none

module mfm_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned CW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [CW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int unsigned RW = (CW > DW + 1) ? CW : DW + 1;
  localparam int unsigned CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    rem;
  logic [DW-1:0]    q;
  logic [RW-1:0]    trial;
  logic [RW-1:0]    div_ext;
  logic             fits;

  assign trial   = {rem[RW-2:0], q[DW-1]};
  assign fits    = trial >= div_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      q       <= dividend;
      div_ext <= RW'(divisor);
    end else if (busy) begin
      rem <= fits ? (trial - div_ext) : trial;
      q   <= {q[DW-2:0], fits};
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

/* src/mains_frequency_monitor.sv */
// Mains frequency monitor top level: config registers, event sequencer,
// result register. Depends on mfm_pkg and mfm_div.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | operation, captured_count, now_ms, timer_now
//  out      | out_valid / out_ready | freq_hz, timed_out, in_window, bad_count,
//           |                       | sleep_request, next_compare
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A capture with an earlier edge and a nonzero period runs CAP, the 24-step
// serial divider, OUT; other captures CAP, OUT; an evaluation EVAL, BAD, OUT;
// a request while asleep only OUT. One request is in work at a time.
// rst is synchronous and restores register defaults and monitor state.
// A result waits in the output register; the sequencer stalls only when
// the next result is ready and the previous one has not been taken.
`default_nettype none

module mains_frequency_monitor #(
  parameter int unsigned COUNTER_WIDTH = mfm_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                operation,
  input  wire mfm_pkg::word_t      captured_count,
  input  wire mfm_pkg::word_t      now_ms,
  input  wire mfm_pkg::word_t      timer_now,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mfm_pkg::freq_t           freq_hz,
  output logic                     timed_out,
  output logic                     in_window,
  output mfm_pkg::bad_t            bad_count,
  output logic                     sleep_request,
  output mfm_pkg::word_t           next_compare,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire mfm_pkg::cfg_idx_t   cfg_index,
  input  wire mfm_pkg::word_t      cfg_data
);

  localparam int unsigned CW = COUNTER_WIDTH;

  // config
  mfm_pkg::clk_hz_t timer_clock_hz;
  mfm_pkg::freq_t   nominal_hz;
  mfm_pkg::freq_t   tolerance_hz;
  mfm_pkg::bad_t    bad_limit;
  mfm_pkg::tmo_t    timeout_ms;
  logic [CW-1:0]    eval_interval;

  // monitor state
  logic [CW-1:0]    prev_capture;
  logic             have_first_edge;
  mfm_pkg::freq_t   freq_value;
  mfm_pkg::word_t   last_edge_ms;
  mfm_pkg::bad_t    bad_counter;
  logic             asleep;

  // latched request and working results
  logic             op;
  logic [CW-1:0]    cap;
  mfm_pkg::word_t   now;
  logic [CW-1:0]    tnow;
  logic             res_tmo;
  logic             res_inwin;
  logic [CW-1:0]    next_sum;
  logic [CW-1:0]    res_next;

  mfm_pkg::mfm_state_t state, state_next;

  logic             div_start;
  logic             div_done;
  mfm_pkg::clk_hz_t div_q;
  logic             out_free;
  logic             out_load;

  logic [CW-1:0]    period;
  mfm_pkg::word_t   age;
  logic             tmo_now;
  logic             inwin_now;
  mfm_pkg::bad_t    bad_new;
  logic             sleep_now;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mfm_pkg::ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= mfm_pkg::RST_TIMER_CLOCK;
      nominal_hz     <= mfm_pkg::RST_TARGET;
      tolerance_hz   <= mfm_pkg::RST_TOLERANCE;
      bad_limit      <= mfm_pkg::RST_BAD_LIMIT;
      timeout_ms     <= mfm_pkg::RST_TIMEOUT;
      eval_interval  <= mfm_pkg::RST_INTERVAL[CW-1:0];
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mfm_pkg::CFG_TIMER_CLOCK: timer_clock_hz <= cfg_data[mfm_pkg::CLK_W-1:0];
        mfm_pkg::CFG_TARGET:      nominal_hz     <= cfg_data[mfm_pkg::FREQ_W-1:0];
        mfm_pkg::CFG_TOLERANCE:   tolerance_hz   <= cfg_data[mfm_pkg::FREQ_W-1:0];
        mfm_pkg::CFG_BAD_LIMIT:   bad_limit      <= cfg_data[mfm_pkg::BAD_W-1:0];
        mfm_pkg::CFG_TIMEOUT:     timeout_ms     <= cfg_data[mfm_pkg::TMO_W-1:0];
        mfm_pkg::CFG_INTERVAL:    eval_interval  <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  mfm_div #(
    .DW(mfm_pkg::CLK_W),
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timer_clock_hz),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_q)
  );

  assign period  = cap - prev_capture;
  assign age     = now - last_edge_ms;
  assign tmo_now = !have_first_edge || (age > mfm_pkg::word_t'(timeout_ms));
  assign inwin_now = ({1'b0, freq_value} + {1'b0, tolerance_hz} >= {1'b0, nominal_hz})
                  && ({1'b0, freq_value} <= {1'b0, nominal_hz} + {1'b0, tolerance_hz});
  assign bad_new = res_inwin ? '0 :
                   (bad_counter == mfm_pkg::BAD_MAX) ? bad_counter : bad_counter + 1'b1;
  assign sleep_now = bad_new >= bad_limit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mfm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (asleep)                         state_next = mfm_pkg::ST_OUT;
          else if (operation == mfm_pkg::OP_EVAL) state_next = mfm_pkg::ST_EVAL;
          else                                state_next = mfm_pkg::ST_CAP;
        end
      end
      mfm_pkg::ST_CAP: begin
        if (have_first_edge && period != '0) state_next = mfm_pkg::ST_DIV;
        else                                 state_next = mfm_pkg::ST_OUT;
      end
      mfm_pkg::ST_DIV:  if (div_done) state_next = mfm_pkg::ST_OUT;
      mfm_pkg::ST_EVAL: state_next = mfm_pkg::ST_BAD;
      mfm_pkg::ST_BAD:  state_next = mfm_pkg::ST_OUT;
      mfm_pkg::ST_OUT:  if (out_free) state_next = mfm_pkg::ST_IDLE;
      default:          state_next = mfm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      mfm_pkg::ST_CAP: div_start = have_first_edge && (period != '0);
      mfm_pkg::ST_OUT: out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfm_pkg::ST_IDLE && in_valid) begin
      op   <= operation;
      cap  <= captured_count[CW-1:0];
      now  <= now_ms;
      tnow <= timer_now[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_capture    <= '0;
      have_first_edge <= 1'b0;
      freq_value      <= '0;
      last_edge_ms    <= '0;
      bad_counter     <= '0;
      asleep          <= 1'b0;
      res_tmo         <= 1'b0;
      res_inwin       <= 1'b0;
      res_next        <= '0;
    end else begin
      unique case (state)
        mfm_pkg::ST_IDLE: begin
          if (in_valid) begin
            res_tmo   <= 1'b0;
            res_inwin <= 1'b0;
            res_next  <= '0;
          end
        end
        mfm_pkg::ST_CAP: begin
          last_edge_ms <= now;
          prev_capture <= cap;
          if (!have_first_edge) begin
            have_first_edge <= 1'b1;
          end else if (period == '0) begin
            have_first_edge <= 1'b0;
            freq_value      <= '0;
          end
        end
        mfm_pkg::ST_DIV: begin
          if (div_done) begin
            freq_value <= (div_q > mfm_pkg::clk_hz_t'(mfm_pkg::FREQ_MAX)) ?
                          mfm_pkg::FREQ_MAX : div_q[mfm_pkg::FREQ_W-1:0];
          end
        end
        mfm_pkg::ST_EVAL: begin
          res_tmo   <= tmo_now;
          res_inwin <= !tmo_now && inwin_now;
          if (tmo_now) begin
            freq_value      <= '0;
            have_first_edge <= 1'b0;
          end
        end
        mfm_pkg::ST_BAD: begin
          bad_counter <= bad_new;
          if (sleep_now) begin
            asleep <= 1'b1;
          end else begin
            res_next <= next_sum;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfm_pkg::ST_EVAL) begin
      next_sum <= tnow + eval_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      freq_hz       <= freq_value;
      timed_out     <= res_tmo;
      in_window     <= res_inwin;
      bad_count     <= bad_counter;
      sleep_request <= asleep;
      next_compare  <= mfm_pkg::word_t'(res_next);
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != mfm_pkg::ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_sleep_sticky: assert property (@(posedge clk) disable iff (rst)
    asleep |=> asleep)
    else $error("sleep flag cleared without reset");

  a_sleep_no_compare: assert property (@(posedge clk) disable iff (rst)
    out_valid && sleep_request |-> next_compare == '0)
    else $error("compare value given while sleep requested");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == mfm_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_capture_path: assert property (@(posedge clk) disable iff (rst)
    state == mfm_pkg::ST_CAP |-> op == mfm_pkg::OP_CAPTURE)
    else $error("capture state entered for an evaluation request");

endmodule

`default_nettype wire

/* tb/mains_frequency_monitor_test.sv */
// Testbench for mains_frequency_monitor: directed and random capture and
// evaluation requests checked against an in-bench monitor predictor.
// Depends on mfm_pkg and the mains_frequency_monitor RTL.
`timescale 1ns / 1ps

typedef struct {
  mfm_pkg::clk_hz_t clock_hz;
  mfm_pkg::freq_t   target;
  mfm_pkg::freq_t   tol;
  mfm_pkg::bad_t    limit;
  mfm_pkg::tmo_t    timeout;
  mfm_pkg::word_t   interval;
} monitor_regs_t;

typedef struct {
  mfm_pkg::word_t prev_capture;
  logic           have_edge;
  mfm_pkg::freq_t freq;
  mfm_pkg::word_t last_edge_ms;
  mfm_pkg::bad_t  bad_cnt;
  logic           asleep;
} monitor_state_t;

typedef struct {
  mfm_pkg::freq_t freq_hz;
  logic           timed_out;
  logic           in_window;
  mfm_pkg::bad_t  bad_count;
  logic           sleep_request;
  mfm_pkg::word_t next_compare;
} monitor_reading_t;

class mfm_scoreboard;
  monitor_regs_t    regs;
  monitor_state_t   st;
  monitor_reading_t expected_readings[$];
  int               errors;

  function new();
    regs = '{mfm_pkg::RST_TIMER_CLOCK, mfm_pkg::RST_TARGET, mfm_pkg::RST_TOLERANCE,
             mfm_pkg::RST_BAD_LIMIT, mfm_pkg::RST_TIMEOUT, mfm_pkg::RST_INTERVAL};
    st = '{'0, 1'b0, '0, '0, '0, 1'b0};
    errors = 0;
  endfunction

  function void write_reg(mfm_pkg::cfg_idx_t idx, mfm_pkg::word_t data);
    case (idx)
      mfm_pkg::CFG_TIMER_CLOCK: regs.clock_hz = data[mfm_pkg::CLK_W-1:0];
      mfm_pkg::CFG_TARGET:      regs.target = data[mfm_pkg::FREQ_W-1:0];
      mfm_pkg::CFG_TOLERANCE:   regs.tol = data[mfm_pkg::FREQ_W-1:0];
      mfm_pkg::CFG_BAD_LIMIT:   regs.limit = data[mfm_pkg::BAD_W-1:0];
      mfm_pkg::CFG_TIMEOUT:     regs.timeout = data[mfm_pkg::TMO_W-1:0];
      mfm_pkg::CFG_INTERVAL:    regs.interval = data;
      default: ;
    endcase
  endfunction

  function monitor_reading_t compute_reading(inout monitor_state_t s, input logic op,
                                             input mfm_pkg::word_t cap,
                                             input mfm_pkg::word_t now,
                                             input mfm_pkg::word_t tnow);
    monitor_reading_t r;
    mfm_pkg::word_t period;
    mfm_pkg::word_t quot;
    mfm_pkg::word_t age;
    int lo;
    int hi;
    r = '{'0, 1'b0, 1'b0, '0, 1'b0, '0};
    if (!s.asleep) begin
      if (op == mfm_pkg::OP_CAPTURE) begin
        s.last_edge_ms = now;
        if (!s.have_edge) begin
          s.prev_capture = cap;
          s.have_edge = 1'b1;
        end else begin
          period = cap - s.prev_capture;
          if (period == 0) begin
            s.have_edge = 1'b0;
            s.freq = '0;
          end else begin
            quot = mfm_pkg::word_t'(regs.clock_hz) / period;
            s.freq = (quot > 255) ? mfm_pkg::FREQ_MAX : quot[mfm_pkg::FREQ_W-1:0];
          end
          s.prev_capture = cap;
        end
      end else begin
        age = now - s.last_edge_ms;
        if (!s.have_edge || age > mfm_pkg::word_t'(regs.timeout)) begin
          r.timed_out = 1'b1;
          s.freq = '0;
          s.have_edge = 1'b0;
        end else begin
          lo = int'(regs.target) - int'(regs.tol);
          hi = int'(regs.target) + int'(regs.tol);
          if (int'(s.freq) >= lo && int'(s.freq) <= hi) r.in_window = 1'b1;
        end
        if (r.in_window) s.bad_cnt = '0;
        else if (s.bad_cnt != mfm_pkg::BAD_MAX) s.bad_cnt = s.bad_cnt + 1'b1;
        if (s.bad_cnt >= regs.limit) s.asleep = 1'b1;
        else r.next_compare = tnow + regs.interval;
      end
    end
    r.freq_hz = s.freq;
    r.bad_count = s.bad_cnt;
    r.sleep_request = s.asleep;
    return r;
  endfunction

  function bit request_would_sleep(logic op, mfm_pkg::word_t cap, mfm_pkg::word_t now,
                                   mfm_pkg::word_t tnow);
    monitor_state_t trial;
    monitor_reading_t r;
    trial = st;
    r = compute_reading(trial, op, cap, now, tnow);
    return r.sleep_request && !st.asleep;
  endfunction

  function void note_request(logic op, mfm_pkg::word_t cap, mfm_pkg::word_t now,
                             mfm_pkg::word_t tnow);
    expected_readings.push_back(compute_reading(st, op, cap, now, tnow));
  endfunction

  function void compare_field(string name, mfm_pkg::word_t want, mfm_pkg::word_t got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(mfm_pkg::freq_t freq_hz, logic timed_out, logic in_window,
                             mfm_pkg::bad_t bad_count, logic sleep_request,
                             mfm_pkg::word_t next_compare);
    monitor_reading_t want;
    if (expected_readings.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual freq %0d bad %0d next %0h",
               $time, freq_hz, bad_count, next_compare);
      errors++;
      return;
    end
    want = expected_readings.pop_front();
    compare_field("freq_hz", mfm_pkg::word_t'(want.freq_hz), mfm_pkg::word_t'(freq_hz));
    compare_field("timed_out", mfm_pkg::word_t'(want.timed_out),
                  mfm_pkg::word_t'(timed_out));
    compare_field("in_window", mfm_pkg::word_t'(want.in_window),
                  mfm_pkg::word_t'(in_window));
    compare_field("bad_count", mfm_pkg::word_t'(want.bad_count),
                  mfm_pkg::word_t'(bad_count));
    compare_field("sleep_request", mfm_pkg::word_t'(want.sleep_request),
                  mfm_pkg::word_t'(sleep_request));
    compare_field("next_compare", want.next_compare, next_compare);
  endfunction
endclass

module mains_frequency_monitor_test;

  localparam mfm_pkg::cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam mfm_pkg::cfg_idx_t CFG_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_MODE = 75;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = mfm_pkg::OP_CAPTURE;
  mfm_pkg::word_t    captured_count = '0;
  mfm_pkg::word_t    now_ms = '0;
  mfm_pkg::word_t    timer_now = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  mfm_pkg::freq_t    freq_hz;
  logic              timed_out;
  logic              in_window;
  mfm_pkg::bad_t     bad_count;
  logic              sleep_request;
  mfm_pkg::word_t    next_compare;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  mfm_pkg::cfg_idx_t cfg_index = mfm_pkg::CFG_TIMER_CLOCK;
  mfm_pkg::word_t    cfg_data = '0;

  mfm_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;

  mains_frequency_monitor u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .captured_count(captured_count),
    .now_ms(now_ms),
    .timer_now(timer_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .freq_hz(freq_hz),
    .timed_out(timed_out),
    .in_window(in_window),
    .bad_count(bad_count),
    .sleep_request(sleep_request),
    .next_compare(next_compare),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check accepted results, random stalls, long holds on request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(freq_hz, timed_out, in_window, bad_count, sleep_request, next_compare);
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  task send_request(logic op, mfm_pkg::word_t cap, mfm_pkg::word_t now,
                    mfm_pkg::word_t tnow);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    captured_count <= cap;
    now_ms <= now;
    timer_now <= tnow;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, cap, now, tnow);
  endtask

  task write_reg(mfm_pkg::cfg_idx_t idx, mfm_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // unused upper data bits carry junk, plus one write to a spare index
  task apply_setting(mfm_pkg::clk_hz_t clock, mfm_pkg::freq_t target, mfm_pkg::freq_t tol,
                     mfm_pkg::bad_t limit, mfm_pkg::tmo_t tmo, mfm_pkg::word_t interval);
    write_reg(mfm_pkg::CFG_TIMER_CLOCK, {8'($urandom), clock});
    write_reg(mfm_pkg::CFG_TARGET, {24'($urandom), target});
    write_reg(mfm_pkg::CFG_TOLERANCE, {24'($urandom), tol});
    write_reg(mfm_pkg::CFG_BAD_LIMIT, {16'($urandom), limit});
    write_reg(mfm_pkg::CFG_TIMEOUT, {16'($urandom), tmo});
    write_reg(mfm_pkg::CFG_INTERVAL, interval);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task wait_drain(int pad);
    in_valid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task set_idle(int src, int snk);
    src_idle_pct = src;
    snk_stall_pct <= snk;
  endtask

  // mostly well-formed edge trains near the window, timely evaluations,
  // some equal captures, fast edges, stale evaluations and noise
  task run_random(int n);
    logic op;
    mfm_pkg::word_t cap;
    mfm_pkg::word_t now;
    mfm_pkg::word_t tnow;
    mfm_pkg::word_t per;
    mfm_pkg::word_t age;
    int r;
    int k;
    int f;
    int lo_f;
    int hi_f;
    int tmo;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      k = k;
      tnow = $urandom;
      tmo = int'(sb.regs.timeout);
      f = $urandom_range(0, 99);
      if (f < 85) age = $urandom_range(0, tmo);
      else if (f < 95) age = tmo + $urandom_range(1, 20);
      else age = $urandom;
      if (r < 8) begin
        op = 1'($urandom_range(0, 1));
        cap = $urandom;
        now = $urandom;
      end else if (r < 55) begin
        op = mfm_pkg::OP_CAPTURE;
        lo_f = int'(sb.regs.target) - int'(sb.regs.tol) - 3;
        if (lo_f < 1) lo_f = 1;
        hi_f = int'(sb.regs.target) + int'(sb.regs.tol) + 3;
        f = $urandom_range(lo_f, hi_f);
        per = mfm_pkg::word_t'(sb.regs.clock_hz) / f;
        if (per == 0) per = 1;
        per = per + $urandom_range(0, 2) - 1;
        r = $urandom_range(0, 99);
        if (r < 4) per = 0;
        else if (r < 8) per = $urandom_range(1, 50);
        else if (r < 12) per = $urandom;
        cap = sb.st.prev_capture + per;
        now = sb.st.last_edge_ms + age;
      end else begin
        op = mfm_pkg::OP_EVAL;
        cap = $urandom;
        now = sb.st.last_edge_ms + age;
      end
      if (sb.request_would_sleep(op, cap, now, tnow)) op = mfm_pkg::OP_CAPTURE;
      send_request(op, cap, now, tnow);
    end
  endtask

  task run_modes(bit with_pressure);
    int m;
    for (m = 0; m < 4; m++) begin
      case (m)
        0: set_idle(0, 0);
        1: set_idle(45, 0);
        2: set_idle(0, 45);
        default: set_idle(34, 34);
      endcase
      if (with_pressure && m == 0) begin
        run_random(20);
        hold_gen <= hold_gen + 1;
        run_random(30);
        wait_drain(2);
        run_random(ITEMS_PER_MODE - 50);
      end else begin
        run_random(ITEMS_PER_MODE);
      end
    end
    wait_drain(8);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 100 kHz clock, 50 +/- 5 Hz, limit 10, 100 ms timeout
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd0, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'hFFFF_FC00, 32'd1000, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'h0000_0400, 32'd1020, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd1040, 32'hFFFF_FF00);
    send_request(mfm_pkg::OP_CAPTURE, 32'h0000_0400, 32'd1060, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd1070, 32'h1234_5678);
    send_request(mfm_pkg::OP_CAPTURE, 32'h5, 32'hFFFF_FFF0, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'h6, 32'hFFFF_FFF8, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'h20, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'h7D6, 32'h30, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'h94, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'h7D6 + 32'd1800, 32'hA0, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'hA0 + 32'd101, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'hFFFF_FFFF, 32'h200, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'hFFFF_FFFF + 32'd2223, 32'h208, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'hFFFF_FFFF, 32'h210, 32'hFFFF_FFFF);
    send_request(mfm_pkg::OP_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drain(4);

    // zero clock, window reaching below zero, zero timeout, full interval
    apply_setting(24'd0, 8'd3, 8'd10, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    send_request(mfm_pkg::OP_CAPTURE, 32'd100, 32'd5000, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'd300, 32'd5000, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd5000, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd5001, 32'h0);
    wait_drain(4);

    apply_setting(mfm_pkg::RST_TIMER_CLOCK, mfm_pkg::RST_TARGET, mfm_pkg::RST_TOLERANCE,
                  16'hFFFF, mfm_pkg::RST_TIMEOUT, mfm_pkg::RST_INTERVAL);
    run_modes(1'b1);
    apply_setting(24'hFF_FFFF, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    run_modes(1'b0);
    apply_setting(24'd1, 8'd0, 8'd255, 16'd1, 16'd0, 32'd1);
    run_modes(1'b0);
    apply_setting(mfm_pkg::clk_hz_t'($urandom_range(1000, 24'hFF_FFFF)),
                  mfm_pkg::freq_t'($urandom_range(20, 200)),
                  mfm_pkg::freq_t'($urandom_range(0, 20)),
                  mfm_pkg::bad_t'($urandom_range(20, 1000)),
                  mfm_pkg::tmo_t'($urandom_range(10, 5000)),
                  $urandom);
    run_modes(1'b0);
    apply_setting(24'd60000, 8'd60, 8'd3, 16'd8, 16'd50, 32'd12345);
    run_modes(1'b0);

    // zero limit: first evaluation requests sleep, then everything is ignored
    set_idle(0, 0);
    apply_setting(mfm_pkg::RST_TIMER_CLOCK, mfm_pkg::RST_TARGET, mfm_pkg::RST_TOLERANCE,
                  16'd0, mfm_pkg::RST_TIMEOUT, mfm_pkg::RST_INTERVAL);
    send_request(mfm_pkg::OP_CAPTURE, 32'd10000, 32'd9000, 32'h0);
    send_request(mfm_pkg::OP_CAPTURE, 32'd12000, 32'd9010, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd9020, 32'h100);
    send_request(mfm_pkg::OP_CAPTURE, 32'd14000, 32'd9030, 32'h0);
    send_request(mfm_pkg::OP_EVAL, 32'h0, 32'd9040, 32'h200);
    send_request(mfm_pkg::OP_EVAL, $urandom, $urandom, $urandom);
    send_request(mfm_pkg::OP_CAPTURE, $urandom, $urandom, $urandom);

    wait_drain(30);
    if (sb.errors == 0) begin
      $display("** mains_frequency_monitor: PASSED **");
    end else begin
      $display("** mains_frequency_monitor: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** mains_frequency_monitor: FAILED **");
    $finish;
  end

endmodule
